// ----- hw/rtl/cdmp_pkg.sv -----
// Package for the colon-delimited message parser.
// Holds result kinds, error codes, character constants and parameter defaults.
// No dependencies.
package cdmp_pkg;

   localparam int MAX_PAYLOAD_DEF  = 1024;
   localparam int MAX_NAME_LEN_DEF = 32;

   localparam logic [7:0] DELIM_CHAR = 8'h3A;
   localparam logic [7:0] DIGIT_LO   = 8'h30;
   localparam logic [7:0] DIGIT_HI   = 8'h39;

   localparam logic [15:0] TYPE_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      KIND_HEADER    = 3'd0,
      KIND_NAME_CHAR = 3'd1,
      KIND_NAME_END  = 3'd2,
      KIND_DATA      = 3'd3,
      KIND_ERROR     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_SIZE      = 2'd1,
      ERR_NAME_LONG = 2'd2
   } err_type;

endpackage

// ----- hw/rtl/colon_delimited_message_parser_top.sv -----
// Colon-delimited message parser, top level.
// Parses "type:size:name:data" one byte per request into header, name,
// name end, data and error results. Depends on cdmp_pkg.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one message byte and a
//   start flag; a set start flag restarts parsing at that byte. Result
//   channel (rsp_valid/rsp_ready) carries at most one result per request.
//   A result is registered: an accepted request waits in the input register,
//   and the parser state and the result register are updated together when
//   it is processed, which a stalled receiver can delay. Throughput is one
//   request per cycle while the receiver does not stall, and is set by the
//   state update between the two registers.
//   Requests that give no result (type and size digits, bytes outside a
//   message) still pass through the input register and update state.
//   When the receiver stalls, the result register holds its result and the
//   input register holds the next request; req_ready drops only when both
//   are full. Reset (synchronous) empties both registers and leaves the
//   parser idle: bytes are ignored until a request with the start flag set.
module colon_delimited_message_parser_top #(
   parameter int MAX_PAYLOAD  = cdmp_pkg::MAX_PAYLOAD_DEF,
   parameter int MAX_NAME_LEN = cdmp_pkg::MAX_NAME_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_start_of_message,
   input  logic [7:0]         req_byte_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cdmp_pkg::kind_type rsp_kind,
   output logic [15:0]        rsp_msg_type,
   output logic [10:0]        rsp_payload_size,
   output logic [7:0]         rsp_out_byte,
   output logic [9:0]         rsp_position,
   output cdmp_pkg::err_type  rsp_error_code,
   output logic               rsp_last
);
   import cdmp_pkg::*;

   localparam int SW = $clog2(MAX_PAYLOAD + 2);
   localparam int NW = $clog2(MAX_NAME_LEN);
   localparam int PW = SW + 4;

   typedef enum logic [2:0] {
      PH_IDLE, PH_TYPE, PH_SIZE, PH_NAME, PH_DATA, PH_STOP
   } phase_type;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic       in_start_ff;
   logic [7:0] in_byte_ff;

   // Parser state
   phase_type     phase_ff, phase_in;
   logic [15:0]   type_acc_ff, type_acc_in;
   logic          type_done_ff, type_done_in;
   logic [SW-1:0] size_acc_ff, size_acc_in;
   logic          size_done_ff, size_done_in;
   logic [NW-1:0] name_cnt_ff, name_cnt_in;
   logic [SW-1:0] data_cnt_ff, data_cnt_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   kind_type      kind_ff, kind_in;
   logic [15:0]   msg_type_ff, msg_type_in;
   logic [10:0]   psize_ff, psize_in;
   logic [7:0]    obyte_ff, obyte_in;
   logic [9:0]    pos_ff, pos_in;
   err_type       err_ff, err_in;
   logic          last_ff, last_in;

   logic          process;
   logic          emit;
   logic          is_digit;
   logic          is_delim;
   logic [19:0]   type_prod;
   logic [PW-1:0] size_prod;
   logic [SW:0]   data_next;

   // Working copies of the state, with a start flag applied
   phase_type     cur_phase;
   logic [15:0]   cur_type;
   logic          cur_type_done;
   logic [SW-1:0] cur_size;
   logic          cur_size_done;
   logic [NW-1:0] cur_name;
   logic [SW-1:0] cur_data;

   assign process   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || process;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   assign is_digit = in_byte_ff inside {[DIGIT_LO:DIGIT_HI]};
   assign is_delim = (in_byte_ff == DELIM_CHAR);

   always_comb begin
      if (in_start_ff) begin
         cur_phase     = PH_TYPE;
         cur_type      = '0;
         cur_type_done = 1'b0;
         cur_size      = '0;
         cur_size_done = 1'b0;
         cur_name      = '0;
         cur_data      = '0;
      end else begin
         cur_phase     = phase_ff;
         cur_type      = type_acc_ff;
         cur_type_done = type_done_ff;
         cur_size      = size_acc_ff;
         cur_size_done = size_done_ff;
         cur_name      = name_cnt_ff;
         cur_data      = data_cnt_ff;
      end
   end

   // Multiply by ten as two shifts and an add
   assign type_prod = (20'(cur_type) << 3) + (20'(cur_type) << 1)
                      + 20'(in_byte_ff[3:0]);
   assign size_prod = (PW'(cur_size) << 3) + (PW'(cur_size) << 1)
                      + PW'(in_byte_ff[3:0]);
   assign data_next = (SW + 1)'(cur_data) + (SW + 1)'(1);

   always_comb begin
      phase_in     = cur_phase;
      type_acc_in  = cur_type;
      type_done_in = cur_type_done;
      size_acc_in  = cur_size;
      size_done_in = cur_size_done;
      name_cnt_in  = cur_name;
      data_cnt_in  = cur_data;
      emit         = 1'b0;
      kind_in      = KIND_HEADER;
      msg_type_in  = cur_type;
      psize_in     = 11'(cur_size);
      obyte_in     = '0;
      pos_in       = '0;
      err_in       = ERR_NONE;
      last_in      = 1'b0;

      case (cur_phase)
         PH_TYPE: begin
            if (is_delim) begin
               phase_in = PH_SIZE;
            end else if (!cur_type_done && is_digit) begin
               if (type_prod > 20'(TYPE_MAX)) begin
                  type_acc_in = TYPE_MAX;
               end else begin
                  type_acc_in = type_prod[15:0];
               end
            end else begin
               type_done_in = 1'b1;
            end
         end
         PH_SIZE: begin
            if (is_delim) begin
               emit = 1'b1;
               if (cur_size > SW'(MAX_PAYLOAD)) begin
                  phase_in = PH_STOP;
                  kind_in  = KIND_ERROR;
                  err_in   = ERR_SIZE;
                  psize_in = '0;
               end else begin
                  phase_in = PH_NAME;
                  kind_in  = KIND_HEADER;
               end
            end else if (!cur_size_done && is_digit) begin
               if (size_prod > PW'(MAX_PAYLOAD + 1)) begin
                  size_acc_in = SW'(MAX_PAYLOAD + 1);
               end else begin
                  size_acc_in = size_prod[SW-1:0];
               end
            end else begin
               size_done_in = 1'b1;
            end
         end
         PH_NAME: begin
            emit = 1'b1;
            if (is_delim) begin
               kind_in = KIND_NAME_END;
               pos_in  = 10'(cur_name);
               if (cur_size == '0) begin
                  last_in  = 1'b1;
                  phase_in = PH_STOP;
               end else begin
                  phase_in = PH_DATA;
               end
            end else if (cur_name >= NW'(MAX_NAME_LEN - 1)) begin
               phase_in = PH_STOP;
               kind_in  = KIND_ERROR;
               err_in   = ERR_NAME_LONG;
            end else begin
               kind_in     = KIND_NAME_CHAR;
               obyte_in    = in_byte_ff;
               pos_in      = 10'(cur_name);
               name_cnt_in = cur_name + NW'(1);
            end
         end
         PH_DATA: begin
            emit        = 1'b1;
            kind_in     = KIND_DATA;
            obyte_in    = in_byte_ff;
            pos_in      = 10'(cur_data);
            data_cnt_in = data_next[SW-1:0];
            if (data_next >= (SW + 1)'(cur_size)) begin
               last_in  = 1'b1;
               phase_in = PH_STOP;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (process) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         type_acc_ff  <= '0;
         type_done_ff <= 1'b0;
         size_acc_ff  <= '0;
         size_done_ff <= 1'b0;
         name_cnt_ff  <= '0;
         data_cnt_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            phase_ff     <= phase_in;
            type_acc_ff  <= type_acc_in;
            type_done_ff <= type_done_in;
            size_acc_ff  <= size_acc_in;
            size_done_ff <= size_done_in;
            name_cnt_ff  <= name_cnt_in;
            data_cnt_ff  <= data_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_start_ff <= req_start_of_message;
         in_byte_ff  <= req_byte_value;
      end
      if (process && emit) begin
         kind_ff     <= kind_in;
         msg_type_ff <= msg_type_in;
         psize_ff    <= psize_in;
         obyte_ff    <= obyte_in;
         pos_ff      <= pos_in;
         err_ff      <= err_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_msg_type     = msg_type_ff;
   assign rsp_payload_size = psize_ff;
   assign rsp_out_byte     = obyte_ff;
   assign rsp_position     = pos_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_last         = last_ff;

endmodule

// ----- hw/rtl/cdmp_checker.sv -----
// Port-level checker for the colon-delimited message parser, with its bind.
// Depends on cdmp_pkg and the ports of colon_delimited_message_parser_top.
module cdmp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_start_of_message,
   input logic [7:0]         req_byte_value,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input cdmp_pkg::kind_type rsp_kind,
   input logic [15:0]        rsp_msg_type,
   input logic [10:0]        rsp_payload_size,
   input logic [7:0]         rsp_out_byte,
   input logic [9:0]         rsp_position,
   input cdmp_pkg::err_type  rsp_error_code,
   input logic               rsp_last
);
   import cdmp_pkg::*;

   // A stalled result must be held unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_out_byte) && $stable(rsp_position) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // Errors carry a code and never close a message.
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_error_code != ERR_NONE && !rsp_last)
      else $error("error result without code or with last set");

   // Only a name end or a data byte can close a message.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_NAME_END || rsp_kind == KIND_DATA)
      else $error("last set on wrong result kind");

endmodule

bind colon_delimited_message_parser_top cdmp_checker u_cdmp_checker (.*);

// ----- tb/cdmp_result_checker.sv -----
// Result checker for the colon-delimited message parser testbench.
// Watches the request and result channels, predicts each result and compares it.
// Depends on cdmp_pkg.
module cdmp_result_checker #(
   parameter int MAX_PAYLOAD  = cdmp_pkg::MAX_PAYLOAD_DEF,
   parameter int MAX_NAME_LEN = cdmp_pkg::MAX_NAME_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_start_of_message,
   input  logic [7:0]         req_byte_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  cdmp_pkg::kind_type rsp_kind,
   input  logic [15:0]        rsp_msg_type,
   input  logic [10:0]        rsp_payload_size,
   input  logic [7:0]         rsp_out_byte,
   input  logic [9:0]         rsp_position,
   input  cdmp_pkg::err_type  rsp_error_code,
   input  logic               rsp_last,
   output int                 mismatch_count,
   output int                 awaiting
);
   import cdmp_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TYPE,
      PH_SIZE,
      PH_NAME,
      PH_DATA,
      PH_DONE
   } parse_phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] msg_type;
      logic [10:0] payload_size;
      logic [7:0]  out_byte;
      logic [9:0]  position;
      err_type     error_code;
      logic        last;
   } parse_result_type;

   parse_phase_type  phase;
   logic [15:0]      type_acc;
   logic             type_stopped;
   int unsigned      size_acc;
   logic             size_stopped;
   int unsigned      name_count;
   int unsigned      data_count;
   parse_result_type expected_results[$];
   int               failures = 0;

   function automatic void clear_parser();
      phase = PH_IDLE;
      type_acc = '0;
      type_stopped = 1'b0;
      size_acc = 0;
      size_stopped = 1'b0;
      name_count = 0;
      data_count = 0;
   endfunction

   // Advances the parser by one request; returns 1 when the request gives a result.
   function automatic bit predict_request(input logic som, input logic [7:0] b,
                                          output parse_result_type res);
      int unsigned acc;
      logic        digit;
      digit = (b >= DIGIT_LO) && (b <= DIGIT_HI);
      if (som) begin
         clear_parser();
         phase = PH_TYPE;
      end
      res = '0;
      res.msg_type = type_acc;
      case (phase)
         PH_TYPE: begin
            if (b == DELIM_CHAR) begin
               phase = PH_SIZE;
            end else if (!type_stopped && digit) begin
               acc = int'(type_acc) * 10 + int'(b) - int'(DIGIT_LO);
               type_acc = (acc > int'(TYPE_MAX)) ? TYPE_MAX : acc[15:0];
            end else begin
               type_stopped = 1'b1;
            end
            return 1'b0;
         end
         PH_SIZE: begin
            if (b == DELIM_CHAR) begin
               if (size_acc > MAX_PAYLOAD) begin
                  phase = PH_DONE;
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_SIZE;
               end else begin
                  phase = PH_NAME;
                  res.kind = KIND_HEADER;
                  res.payload_size = 11'(size_acc);
               end
               return 1'b1;
            end
            if (!size_stopped && digit) begin
               size_acc = size_acc * 10 + int'(b) - int'(DIGIT_LO);
               if (size_acc > MAX_PAYLOAD + 1)
                  size_acc = MAX_PAYLOAD + 1;
            end else begin
               size_stopped = 1'b1;
            end
            return 1'b0;
         end
         PH_NAME: begin
            res.payload_size = 11'(size_acc);
            if (b == DELIM_CHAR) begin
               res.kind = KIND_NAME_END;
               res.position = 10'(name_count);
               res.last = (size_acc == 0);
               phase = res.last ? PH_DONE : PH_DATA;
            end else if (name_count >= MAX_NAME_LEN - 1) begin
               // The name has no room left for this byte, so the message is dropped.
               phase = PH_DONE;
               res.kind = KIND_ERROR;
               res.error_code = ERR_NAME_LONG;
            end else begin
               res.kind = KIND_NAME_CHAR;
               res.out_byte = b;
               res.position = 10'(name_count);
               name_count++;
            end
            return 1'b1;
         end
         PH_DATA: begin
            res.kind = KIND_DATA;
            res.payload_size = 11'(size_acc);
            res.out_byte = b;
            res.position = 10'(data_count);
            res.last = (data_count + 1 >= size_acc);
            data_count++;
            if (res.last)
               phase = PH_DONE;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      parse_result_type predicted;
      parse_result_type seen;
      parse_result_type want;
      if (reset) begin
         clear_parser();
         expected_results.delete();
      end else begin
         // Results are taken before requests: a request never yields a result on the
         // edge that accepts it.
         if (rsp_valid && rsp_ready) begin
            seen.kind = rsp_kind;
            seen.msg_type = rsp_msg_type;
            seen.payload_size = rsp_payload_size;
            seen.out_byte = rsp_out_byte;
            seen.position = rsp_position;
            seen.error_code = rsp_error_code;
            seen.last = rsp_last;
            if (expected_results.size() == 0) begin
               if (failures < 10)
                  $display({"checker: unexpected result at %0t: ",
                            "kind=%0d type=%0d size=%0d"},
                           $time, seen.kind, seen.msg_type, seen.payload_size);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  if (failures < 10) begin
                     $display("checker: mismatch at %0t", $time);
                     $display({"  expected kind=%0d type=%0d size=%0d byte=%02h ",
                               "pos=%0d err=%0d last=%0b"},
                              want.kind, want.msg_type, want.payload_size, want.out_byte,
                              want.position, want.error_code, want.last);
                     $display({"  actual   kind=%0d type=%0d size=%0d byte=%02h ",
                               "pos=%0d err=%0d last=%0b"},
                              seen.kind, seen.msg_type, seen.payload_size, seen.out_byte,
                              seen.position, seen.error_code, seen.last);
                  end
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (predict_request(req_start_of_message, req_byte_value, predicted))
               expected_results.push_back(predicted);
         end
      end
      mismatch_count <= failures;
      awaiting <= expected_results.size();
   end

endmodule

// ----- tb/testbench.sv -----
// Top of the colon-delimited message parser testbench: clock, reset, request
// stimulus and result back-pressure. Depends on cdmp_pkg, the parser top level
// and cdmp_result_checker.
module testbench;
   import cdmp_pkg::*;

   localparam int MAX_PAYLOAD  = MAX_PAYLOAD_DEF;
   localparam int MAX_NAME_LEN = MAX_NAME_LEN_DEF;
   localparam int ITEM_TARGET  = 1900;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_start_of_message = 1'b0;
   logic [7:0]  req_byte_value = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   kind_type    rsp_kind;
   logic [15:0] rsp_msg_type;
   logic [10:0] rsp_payload_size;
   logic [7:0]  rsp_out_byte;
   logic [9:0]  rsp_position;
   err_type     rsp_error_code;
   logic        rsp_last;

   int mismatch_count;
   int awaiting;
   int sent = 0;
   int cycles = 0;
   int rsp_hold = 0;
   bit idle_off = 1'b0;
   bit calm_req = 1'b0;
   bit calm_rsp = 1'b0;

   always #5 clock = ~clock;

   colon_delimited_message_parser_top #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .MAX_NAME_LEN(MAX_NAME_LEN)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_start_of_message(req_start_of_message),
      .req_byte_value(req_byte_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_msg_type(rsp_msg_type),
      .rsp_payload_size(rsp_payload_size),
      .rsp_out_byte(rsp_out_byte),
      .rsp_position(rsp_position),
      .rsp_error_code(rsp_error_code),
      .rsp_last(rsp_last)
   );

   cdmp_result_checker #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .MAX_NAME_LEN(MAX_NAME_LEN)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_start_of_message(req_start_of_message),
      .req_byte_value(req_byte_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_msg_type(rsp_msg_type),
      .rsp_payload_size(rsp_payload_size),
      .rsp_out_byte(rsp_out_byte),
      .rsp_position(rsp_position),
      .rsp_error_code(rsp_error_code),
      .rsp_last(rsp_last),
      .mismatch_count(mismatch_count),
      .awaiting(awaiting)
   );

   // Receiver back-pressure: random bursts of stalled cycles, with calm stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else begin
         if ($urandom_range(0, 63) == 0)
            calm_rsp <= ~calm_rsp;
         if (!idle_off && !calm_rsp && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            rsp_hold <= $urandom_range(1, 4);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic logic [7:0] pick_byte(input logic digit_ok);
      logic [7:0] b;
      do
         b = 8'($urandom);
      while (b == DELIM_CHAR || (!digit_ok && b >= DIGIT_LO && b <= DIGIT_HI));
      return b;
   endfunction

   // Called at a rising edge; returns at the edge that accepts the request.
   task automatic send_byte(input logic som, input logic [7:0] value);
      if (!idle_off && !calm_req && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_of_message <= som;
      req_byte_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_text(input string text);
      for (int k = 0; k < text.len(); k++)
         send_byte(k == 0, text[k]);
   endtask

   // One message with random content; a negative request means a random choice.
   task automatic send_message(input int name_req, input int size_req);
      logic [7:0] text[$];
      string      digits;
      int         size_val;
      int         name_len;
      int         data_len;
      int         count;
      int         pick;
      calm_req = ($urandom_range(0, 3) == 0);
      data_len = -1;
      repeat ($urandom_range(0, 7)) text.push_back(DIGIT_LO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) begin
         text.push_back(pick_byte(1'b0));
         repeat ($urandom_range(0, 2)) text.push_back(pick_byte(1'b1));
      end
      text.push_back(DELIM_CHAR);

      if (size_req >= 0) begin
         size_val = size_req;
      end else begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            size_val = $urandom_range(0, 12);
         end else if (pick < 17) begin
            size_val = $urandom_range(MAX_PAYLOAD + 1, 99999);
            data_len = $urandom_range(0, 3);
         end else begin
            // A large size is declared, but the next start cuts the data short.
            size_val = $urandom_range(13, MAX_PAYLOAD);
            data_len = $urandom_range(0, 20);
         end
      end
      if (data_len < 0)
         data_len = size_val;
      digits = $sformatf("%0d", size_val);
      if ($urandom_range(0, 7) == 0)
         digits = {"00", digits};
      for (int k = 0; k < digits.len(); k++)
         text.push_back(digits[k]);
      if ($urandom_range(0, 7) == 0)
         text.push_back(pick_byte(1'b0));
      text.push_back(DELIM_CHAR);

      if (name_req >= 0)
         name_len = name_req;
      else if ($urandom_range(0, 7) == 0)
         name_len = $urandom_range(MAX_NAME_LEN - 4, MAX_NAME_LEN + 2);
      else
         name_len = $urandom_range(0, 8);
      repeat (name_len) text.push_back(pick_byte(1'b1));
      text.push_back(DELIM_CHAR);
      repeat (data_len) text.push_back(8'($urandom));

      count = text.size();
      if (name_req < 0 && size_req < 0 && $urandom_range(0, 9) == 0)
         count = $urandom_range(1, text.size());
      for (int k = 0; k < count; k++) begin
         send_byte(k == 0, text[k]);
         sent++;
      end
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom));
   endtask

   initial begin
      int msg_no;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_byte(1'b0, 8'hFF);        // ignored: no message has started yet
      send_text("99999:0::");        // type saturates, empty name and data
      send_byte(1'b0, 8'h00);        // ignored after a complete message
      send_text("7x5:2:A::");        // junk in the type field, colon as data
      send_byte(1'b0, 8'hFF);
      send_text(":9999:");           // size above the limit

      msg_no = 0;
      while (sent < ITEM_TARGET) begin
         if (msg_no == 0)
            send_message(MAX_NAME_LEN + 2, 3);
         else if (msg_no == 7)
            send_message(5, MAX_PAYLOAD);
         else
            send_message(-1, -1);
         msg_no++;
         if (sent >= ITEM_TARGET - 250)
            idle_off = 1'b1;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && awaiting == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
